// ===== design/hfs_pkg.sv =====
package hfs_pkg;

    localparam int TIME_W    = 32;
    localparam int DUR_W     = 16;
    localparam int ID_W      = 16;
    localparam int IDX_W     = 3;
    localparam int NUM_DUR   = 8;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STAGES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MACHINES = 2'd1;

    localparam logic [CNT_W-1:0]     STAGE_CNT_RST = 4'd1;
    localparam logic [TIME_W-1:0]    MCOUNT_RST    = 32'h1111_1111;
    localparam logic [TIME_W-1:0]    TIME_MAX      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic             start_new;
        logic             final_task;
        logic [ID_W-1:0]  task_id;
        logic [DUR_W-1:0] dur_s0;
        logic [DUR_W-1:0] dur_s1;
        logic [DUR_W-1:0] dur_s2;
        logic [DUR_W-1:0] dur_s3;
        logic [DUR_W-1:0] dur_s4;
        logic [DUR_W-1:0] dur_s5;
        logic [DUR_W-1:0] dur_s6;
        logic [DUR_W-1:0] dur_s7;
    } t_in_word;

    typedef struct packed {
        logic [ID_W-1:0]   out_task;
        logic [IDX_W-1:0]  stage_index;
        logic [IDX_W-1:0]  machine_index;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [TIME_W-1:0] makespan;
        logic              schedule_done;
        logic              last_of_run;
    } t_out_word;

endpackage

// ===== design/hfs_intf.sv =====
interface hfs_in_if;
    logic              valid;
    logic              ready;
    hfs_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hfs_out_if;
    logic               valid;
    logic               ready;
    hfs_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hfs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hfs_pkg::CFG_IDX_W-1:0]    index;
    logic [hfs_pkg::CFG_DAT_W-1:0]    wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== design/hfs_ft_mem.sv =====
module hfs_ft_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clr,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [hfs_pkg::TIME_W-1:0] i_wdata,
    output logic [hfs_pkg::TIME_W-1:0] o_rdata
);

    logic [hfs_pkg::TIME_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_vld;
    logic [DEPTH-1:0]           n_vld;
    logic [hfs_pkg::TIME_W-1:0] r_rdata;
    logic                       r_rvld;

    // entries never written since clear read as zero
    always_comb begin
        n_vld = r_vld;
        if (i_clr) begin
            n_vld = '0;
        end else if (i_we) begin
            n_vld[i_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// ===== design/hybrid_flow_shop_schedule_decoder_top.sv =====
// channel | dir | handshake        | word
// i_in    | in  | valid/ready      | start_new, final_task, task_id, dur_s0..dur_s7
// o_out   | out | valid/ready      | one result per stage in use
// i_cfg   | in  | valid/ready      | index, wdata (0: stage_count, 1: machine_counts)
//
// A task is taken in IDLE, then each stage in use runs READ, SCAN, START, END, EMIT:
// one free-time memory read per machine feeding the single comparator, then start,
// end and emit steps.
// Reset is synchronous; free-time valid bits clear together, with no sweep.
// The emit step waits while the result register is full and not taken.
module hybrid_flow_shop_schedule_decoder_top #(
    parameter int MAX_STAGES   = 8,
    parameter int MAX_MACHINES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hfs_in_if.sink           i_in,
    hfs_out_if.source        o_out,
    hfs_cfg_if.sink          i_cfg
);

    localparam int MW    = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int SW    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int DEPTH = MAX_STAGES * MAX_MACHINES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = hfs_pkg::TIME_W;
    localparam int CW    = hfs_pkg::CNT_W;

    localparam logic [CW-1:0] MAX_ST = CW'(MAX_STAGES);
    localparam logic [CW-1:0] MAX_MC = CW'(MAX_MACHINES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_END   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]                  r_state, n_state;
    hfs_pkg::t_in_word           r_item, n_item;
    logic [SW-1:0]               r_stage, n_stage;
    logic [MW:0]                 r_mach, n_mach;
    logic [MW-1:0]               r_cmp, n_cmp;
    logic [MW-1:0]               r_best_idx, n_best_idx;
    logic [TW-1:0]               r_best, n_best;
    logic [TW-1:0]               r_prev_end, n_prev_end;
    logic [TW-1:0]               r_prev_start [MAX_STAGES];
    logic [TW-1:0]               n_prev_start [MAX_STAGES];
    logic [TW-1:0]               r_makespan, n_makespan;
    logic [TW-1:0]               r_start, n_start;
    logic [TW-1:0]               r_end, n_end;
    hfs_pkg::t_out_word          r_out, n_out;
    logic                        r_out_valid, n_out_valid;
    logic [CW-1:0]               r_stage_cnt, n_stage_cnt;
    logic [TW-1:0]               r_mcounts, n_mcounts;

    logic [hfs_pkg::DUR_W-1:0]   dur [hfs_pkg::NUM_DUR];
    logic [CW-1:0]               nst;
    logic [CW-1:0]               nm;
    logic [CW-1:0]               nm_raw;
    logic                        last;
    logic                        out_free;
    logic [TW-1:0]               max_a;
    logic [TW:0]                 sum;
    logic [TW-1:0]               ps_cur;

    logic                        mem_clr;
    logic                        mem_re;
    logic [MW-1:0]               mem_ridx;
    logic                        mem_we;
    logic [AW-1:0]               mem_raddr;
    logic [AW-1:0]               mem_waddr;
    logic [TW-1:0]               mem_rdata;

    assign dur[0] = r_item.dur_s0;
    assign dur[1] = r_item.dur_s1;
    assign dur[2] = r_item.dur_s2;
    assign dur[3] = r_item.dur_s3;
    assign dur[4] = r_item.dur_s4;
    assign dur[5] = r_item.dur_s5;
    assign dur[6] = r_item.dur_s6;
    assign dur[7] = r_item.dur_s7;

    always_comb begin
        nst = r_stage_cnt;
        if (nst == '0) begin
            nst = CW'(1);
        end else if (nst > MAX_ST) begin
            nst = MAX_ST;
        end
        nm_raw = r_mcounts[{3'(r_stage), 2'b00} +: CW];
        nm = nm_raw;
        if (nm_raw == '0) begin
            nm = CW'(1);
        end else if (nm_raw > MAX_MC) begin
            nm = MAX_MC;
        end
    end

    assign last      = (CW'(r_stage) + CW'(1)) == nst;
    assign out_free  = !r_out_valid || o_out.ready;
    assign ps_cur    = r_prev_start[r_stage];
    assign max_a     = (r_best > r_prev_end) ? r_best : r_prev_end;
    assign sum       = {1'b0, r_start} + {{(TW + 1 - hfs_pkg::DUR_W){1'b0}}, dur[3'(r_stage)]};
    assign mem_raddr = AW'(AW'(r_stage) * AW'(MAX_MACHINES) + AW'(mem_ridx));
    assign mem_waddr = AW'(AW'(r_stage) * AW'(MAX_MACHINES) + AW'(r_best_idx));

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_stage      = r_stage;
        n_mach       = r_mach;
        n_cmp        = r_cmp;
        n_best_idx   = r_best_idx;
        n_best       = r_best;
        n_prev_end   = r_prev_end;
        n_prev_start = r_prev_start;
        n_makespan   = r_makespan;
        n_start      = r_start;
        n_end        = r_end;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_stage_cnt  = r_stage_cnt;
        n_mcounts    = r_mcounts;
        mem_clr      = 1'b0;
        mem_re       = 1'b0;
        mem_ridx     = '0;
        mem_we       = 1'b0;

        if (i_cfg.valid) begin
            case (i_cfg.index)
                hfs_pkg::CFG_IDX_STAGES:   n_stage_cnt = i_cfg.wdata[CW-1:0];
                hfs_pkg::CFG_IDX_MACHINES: n_mcounts   = i_cfg.wdata;
                default: ;
            endcase
        end

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_item     = i_in.data;
                    n_stage    = '0;
                    n_prev_end = '0;
                    if (i_in.data.start_new) begin
                        mem_clr    = 1'b1;
                        n_makespan = '0;
                        for (int i = 0; i < MAX_STAGES; i++) begin
                            n_prev_start[i] = '0;
                        end
                    end
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                mem_re   = 1'b1;
                mem_ridx = '0;
                n_mach   = (MW + 1)'(1);
                n_cmp    = '0;
                n_state  = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_cmp == '0 || mem_rdata < r_best) begin
                    n_best     = mem_rdata;
                    n_best_idx = r_cmp;
                end
                if (CW'(r_mach) < nm) begin
                    mem_re   = 1'b1;
                    mem_ridx = r_mach[MW-1:0];
                    n_cmp    = r_mach[MW-1:0];
                    n_mach   = r_mach + (MW + 1)'(1);
                end else begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_start = (ps_cur > max_a) ? ps_cur : max_a;
                n_state = ST_END;
            end
            ST_END: begin
                n_end   = sum[TW] ? hfs_pkg::TIME_MAX : sum[TW-1:0];
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    mem_we                = 1'b1;
                    n_prev_start[r_stage] = r_start;
                    n_prev_end            = r_end;
                    n_out.out_task        = r_item.task_id;
                    n_out.stage_index     = 3'(r_stage);
                    n_out.machine_index   = 3'(r_best_idx);
                    n_out.start_time      = r_start;
                    n_out.end_time        = r_end;
                    n_out.makespan        = r_makespan;
                    n_out.schedule_done   = last && r_item.final_task;
                    n_out.last_of_run     = last;
                    n_out_valid           = 1'b1;
                    if (last) begin
                        if (r_end > r_makespan) begin
                            n_makespan     = r_end;
                            n_out.makespan = r_end;
                        end
                        n_state = ST_IDLE;
                    end else begin
                        n_stage = r_stage + SW'(1);
                        n_state = ST_READ;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_stage_cnt <= hfs_pkg::STAGE_CNT_RST;
            r_mcounts   <= hfs_pkg::MCOUNT_RST;
            r_makespan  <= '0;
            for (int i = 0; i < MAX_STAGES; i++) begin
                r_prev_start[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_stage_cnt  <= n_stage_cnt;
            r_mcounts    <= n_mcounts;
            r_makespan   <= n_makespan;
            r_prev_start <= n_prev_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_stage    <= n_stage;
        r_mach     <= n_mach;
        r_cmp      <= n_cmp;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_prev_end <= n_prev_end;
        r_start    <= n_start;
        r_end      <= n_end;
        r_out      <= n_out;
    end

    hfs_ft_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ft_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (mem_clr),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_end),
        .o_rdata (mem_rdata)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
